>>> rtl/i2crm_pkg.sv
// shared types and constants of the i2c register master
`default_nettype none
package i2crm_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_POST_WRITE_WAIT = 1'b0;
    localparam logic [15:0] POST_WRITE_WAIT_RESET = 16'd2000;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       ack_missing;
        logic       busy_res;
        logic       done_res;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/i2crm_cmd_if.sv
// command channel of the i2c register master
`default_nettype none
interface i2crm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;

    modport source (
        output valid, command, device_address, register_address, write_data,
               read_count, sda_in,
        input  ready
    );
    modport sink (
        input  valid, command, device_address, register_address, write_data,
               read_count, sda_in,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/i2crm_res_if.sv
// result channel of the i2c register master
`default_nettype none
interface i2crm_res_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       ack_missing;
    logic       busy_res;
    logic       done_res;

    modport source (
        output valid, scl, sda_out, read_data, read_valid, ack_missing, busy_res,
               done_res,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_out, read_data, read_valid, ack_missing, busy_res,
               done_res,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/i2crm_engine.sv
// bus sequencer: one pin step per accepted tick
`default_nettype none
module i2crm_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire i2crm_pkg::t_item   i_item,
    input  wire logic [15:0]        i_post_write_wait,
    output i2crm_pkg::t_result      o_result
);
    import i2crm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_TXA, PH_AK1, PH_TXR, PH_AK2, PH_TXD, PH_AK3,
        PH_RST, PH_TXAR, PH_AK4, PH_RREL, PH_RBIT, PH_RACK, PH_STOP, PH_WAIT
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  sub_step;
        logic [2:0]  bit_index;
        logic [7:0]  bytes_left;
        logic [7:0]  shift_byte;
        logic [15:0] wait_count;
        logic [6:0]  held_device;
        logic [7:0]  held_register;
        logic [7:0]  held_data;
        logic        is_read;
        logic        scl_level;
        logic        sda_level;
    } t_st;

    localparam t_st ST_RESET = '{
        phase: PH_IDLE, sub_step: 2'd0, bit_index: 3'd0, bytes_left: 8'd0,
        shift_byte: 8'd0, wait_count: 16'd0, held_device: 7'd0,
        held_register: 8'd0, held_data: 8'd0, is_read: 1'b0,
        scl_level: 1'b1, sda_level: 1'b1
    };

    t_st  r_st;
    t_st  n_st;
    logic nack;
    logic done;
    logic rvalid;
    logic [7:0] rdata;
    logic [7:0] left_dec;

    // phase entry: clear counters, load the byte to send
    function automatic t_st enter_ph(input t_st s, input t_phase p);
        t_st t;
        t = s;
        t.phase     = p;
        t.sub_step  = 2'd0;
        t.bit_index = 3'd0;
        unique case (p)
            PH_TXA:  t.shift_byte = {s.held_device, 1'b0};
            PH_TXAR: t.shift_byte = {s.held_device, 1'b1};
            PH_TXR:  t.shift_byte = s.held_register;
            PH_TXD:  t.shift_byte = s.held_data;
            default: t.shift_byte = s.shift_byte;
        endcase
        return t;
    endfunction

    always_comb begin
        n_st     = r_st;
        nack     = 1'b0;
        done     = 1'b0;
        rvalid   = 1'b0;
        rdata    = 8'd0;
        left_dec = (r_st.bytes_left != 8'd0) ? r_st.bytes_left - 8'd1 : 8'd0;
        if (r_st.phase == PH_IDLE) begin
            if (i_item.command == CMD_WRITE || i_item.command == CMD_READ) begin
                n_st.held_device   = i_item.device_address;
                n_st.held_register = i_item.register_address;
                n_st.held_data     = i_item.write_data;
                n_st.bytes_left    = (i_item.read_count == 8'd0) ? 8'd1 : i_item.read_count;
                n_st.is_read       = (i_item.command == CMD_READ);
                n_st               = enter_ph(n_st, PH_START);
            end
        end else if (i_item.command == CMD_TICK) begin
            unique case (r_st.phase) inside
                PH_START, PH_RST: begin
                    n_st.sub_step = r_st.sub_step + 2'd1;
                    case (r_st.sub_step)
                        2'd0: n_st.sda_level = 1'b1;
                        2'd1: n_st.scl_level = 1'b1;
                        2'd2: n_st.sda_level = 1'b0;
                        default: begin
                            n_st.scl_level = 1'b0;
                            n_st = enter_ph(n_st,
                                (r_st.phase == PH_START) ? PH_TXA : PH_TXAR);
                        end
                    endcase
                end
                PH_TXA, PH_TXR, PH_TXD, PH_TXAR: begin
                    case (r_st.sub_step)
                        2'd0: begin
                            n_st.sda_level = r_st.shift_byte[7];
                            n_st.sub_step  = 2'd1;
                        end
                        2'd1: begin
                            n_st.scl_level = 1'b1;
                            n_st.sub_step  = 2'd2;
                        end
                        default: begin
                            n_st.scl_level  = 1'b0;
                            n_st.shift_byte = {r_st.shift_byte[6:0], 1'b0};
                            n_st.sub_step   = 2'd0;
                            if (r_st.bit_index == 3'd7) begin
                                unique case (r_st.phase)
                                    PH_TXA:  n_st = enter_ph(n_st, PH_AK1);
                                    PH_TXR:  n_st = enter_ph(n_st, PH_AK2);
                                    PH_TXD:  n_st = enter_ph(n_st, PH_AK3);
                                    default: n_st = enter_ph(n_st, PH_AK4);
                                endcase
                            end else begin
                                n_st.bit_index = r_st.bit_index + 3'd1;
                            end
                        end
                    endcase
                end
                PH_AK1, PH_AK2, PH_AK3, PH_AK4: begin
                    n_st.sub_step = r_st.sub_step + 2'd1;
                    case (r_st.sub_step)
                        2'd0: n_st.sda_level = 1'b1;
                        2'd1: n_st.scl_level = 1'b1;
                        2'd2: nack = i_item.sda_in;
                        default: begin
                            n_st.scl_level = 1'b0;
                            unique case (r_st.phase)
                                PH_AK1:  n_st = enter_ph(n_st, PH_TXR);
                                PH_AK2:  n_st = enter_ph(n_st,
                                             r_st.is_read ? PH_RST : PH_TXD);
                                PH_AK3:  n_st = enter_ph(n_st, PH_STOP);
                                default: n_st = enter_ph(n_st, PH_RREL);
                            endcase
                        end
                    endcase
                end
                PH_RREL: begin
                    n_st.sda_level  = 1'b1;
                    n_st            = enter_ph(n_st, PH_RBIT);
                    n_st.shift_byte = 8'd0;
                end
                PH_RBIT: begin
                    case (r_st.sub_step)
                        2'd0: begin
                            n_st.scl_level = 1'b1;
                            n_st.sub_step  = 2'd1;
                        end
                        2'd1: begin
                            n_st.shift_byte = {r_st.shift_byte[6:0], i_item.sda_in};
                            n_st.sub_step   = 2'd2;
                        end
                        default: begin
                            n_st.scl_level = 1'b0;
                            n_st.sub_step  = 2'd0;
                            if (r_st.bit_index == 3'd7) begin
                                n_st.phase     = PH_RACK;
                                n_st.bit_index = 3'd0;
                            end else begin
                                n_st.bit_index = r_st.bit_index + 3'd1;
                            end
                        end
                    endcase
                end
                PH_RACK: begin
                    case (r_st.sub_step)
                        2'd0: begin
                            // ack every byte but the last
                            n_st.sda_level = (r_st.bytes_left > 8'd1) ? 1'b0 : 1'b1;
                            n_st.sub_step  = 2'd1;
                        end
                        2'd1: begin
                            n_st.scl_level = 1'b1;
                            n_st.sub_step  = 2'd2;
                        end
                        default: begin
                            n_st.scl_level  = 1'b0;
                            rdata           = r_st.shift_byte;
                            rvalid          = 1'b1;
                            n_st.bytes_left = left_dec;
                            n_st = enter_ph(n_st, (left_dec != 8'd0) ? PH_RREL : PH_STOP);
                        end
                    endcase
                end
                PH_STOP: begin
                    case (r_st.sub_step)
                        2'd0: begin
                            n_st.sda_level = 1'b0;
                            n_st.sub_step  = 2'd1;
                        end
                        2'd1: begin
                            n_st.scl_level = 1'b1;
                            n_st.sub_step  = 2'd2;
                        end
                        default: begin
                            n_st.sda_level = 1'b1;
                            if (r_st.is_read || i_post_write_wait == 16'd0) begin
                                done = 1'b1;
                                n_st = enter_ph(n_st, PH_IDLE);
                            end else begin
                                n_st.wait_count = i_post_write_wait;
                                n_st = enter_ph(n_st, PH_WAIT);
                            end
                        end
                    endcase
                end
                default: begin
                    // post-write wait
                    if (r_st.wait_count != 16'd0)
                        n_st.wait_count = r_st.wait_count - 16'd1;
                    if (n_st.wait_count == 16'd0) begin
                        done = 1'b1;
                        n_st = enter_ph(n_st, PH_IDLE);
                    end
                end
            endcase
        end

        o_result.scl         = n_st.scl_level;
        o_result.sda_out     = n_st.sda_level;
        o_result.read_data   = rdata;
        o_result.read_valid  = rvalid;
        o_result.ack_missing = nack;
        o_result.busy_res    = (n_st.phase != PH_IDLE);
        o_result.done_res    = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule
`default_nettype wire

>>> rtl/i2c_register_master_core.sv
// top level of the i2c register master: config port, sequencer, result register
//
// Open-drain I2C master for single-byte register writes and multi-byte
// register reads. Every command beat is one pin-update time: a beat with
// command tick moves the bus sequence on by one step (one pin change or one
// SDA sample, with i_cmd.sda_in taken on sample steps), while a write or read
// command beat latches its operands when the master is idle and is ignored
// while busy. Every accepted command beat yields exactly one result beat
// showing the pin drive after the step, any completed read byte, a missing
// ack flag, busy and done. A new command beat is taken every clock cycle;
// the result appears in the cycle after acceptance from an output register, and
// the command side stalls only while that register holds a beat that the
// result side has not taken. The sequencer step is a single pass of small
// next-state logic between the sequencer registers and the output register.
// post_write_wait (byte address 0, reset 2000) sets how many ticks busy stays
// up after a write's stop; write it only while the master is idle.
`default_nettype none
module i2c_register_master_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    i2crm_cmd_if.sink                                 i_cmd,
    i2crm_res_if.source                               o_res,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [i2crm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [i2crm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [i2crm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready
);
    import i2crm_pkg::*;

    logic [15:0] r_post_write_wait;
    logic        r_out_valid;
    t_result     r_out;
    t_item       cmd_item;
    t_result     step_res;
    logic        cmd_take;
    logic        cfg_sel;

    // register index is the word address
    assign cfg_sel = (paddr[APB_ADDR_W-1] == REG_POST_WRITE_WAIT);
    assign pready  = 1'b1;

    always_comb begin
        prdata = '0;
        if (cfg_sel)
            prdata = {{(APB_DATA_W-16){1'b0}}, r_post_write_wait};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_write_wait <= POST_WRITE_WAIT_RESET;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_post_write_wait <= pwdata[15:0];
        end
    end

    // command beat into the sequencer
    assign cmd_item.command          = i_cmd.command;
    assign cmd_item.device_address   = i_cmd.device_address;
    assign cmd_item.register_address = i_cmd.register_address;
    assign cmd_item.write_data       = i_cmd.write_data;
    assign cmd_item.read_count       = i_cmd.read_count;
    assign cmd_item.sda_in           = i_cmd.sda_in;

    // take a beat when the output register is free or being drained
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    i2crm_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (cmd_take),
        .i_item            (cmd_item),
        .i_post_write_wait (r_post_write_wait),
        .o_result          (step_res)
    );

    // result register, only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scl         = r_out.scl;
    assign o_res.sda_out     = r_out.sda_out;
    assign o_res.read_data   = r_out.read_data;
    assign o_res.read_valid  = r_out.read_valid;
    assign o_res.ack_missing = r_out.ack_missing;
    assign o_res.busy_res    = r_out.busy_res;
    assign o_res.done_res    = r_out.done_res;

endmodule
`default_nettype wire

>>> rtl/i2crm_check.sv
// port-level assertions of the i2c register master and their bind
`default_nettype none
module i2crm_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       scl,
    input wire logic       sda_out,
    input wire logic [7:0] read_data,
    input wire logic       read_valid,
    input wire logic       ack_missing,
    input wire logic       busy_res,
    input wire logic       done_res
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(scl)
            && $stable(sda_out) && $stable(busy_res) && $stable(done_res))
        else $error("result beat changed while stalled");

    // read data is zero unless a byte completes
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !read_valid |-> read_data == 8'd0)
        else $error("read data without read valid");

    // done ends the transaction and never shares a beat with a read byte
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && done_res |-> !busy_res && !read_valid && !ack_missing)
        else $error("done with busy, read byte or ack flag");

    // an idle bus has both lines released
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !busy_res |-> scl && sda_out)
        else $error("bus not released while idle");

endmodule

bind i2c_register_master_core i2crm_check u_i2crm_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .res_valid   (o_res.valid),
    .res_ready   (o_res.ready),
    .scl         (o_res.scl),
    .sda_out     (o_res.sda_out),
    .read_data   (o_res.read_data),
    .read_valid  (o_res.read_valid),
    .ack_missing (o_res.ack_missing),
    .busy_res    (o_res.busy_res),
    .done_res    (o_res.done_res)
);
`default_nettype wire

>>> tb/sv/i2crm_tb_pkg.sv
// bus sequence predictor and result scoreboard for the i2c register master bench
package i2crm_tb_pkg;
    import i2crm_pkg::*;

    // command code that the master never acts on
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START, SEQ_ADDR_W, SEQ_ACK_ADDR, SEQ_REG, SEQ_ACK_REG,
        SEQ_DATA, SEQ_ACK_DATA, SEQ_RESTART, SEQ_ADDR_R, SEQ_ACK_ADDR_R,
        SEQ_RELEASE, SEQ_RD_BIT, SEQ_RD_ACK, SEQ_STOP, SEQ_HOLD
    } t_seq;

    class pin_scoreboard;
        t_seq        seq;
        int unsigned sub;
        logic [2:0]  bit_cnt;
        logic [7:0]  bytes_left;
        logic [7:0]  shreg;
        logic [15:0] hold_left;
        logic [15:0] hold_ticks;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  wr_byte;
        logic        rd_xfer;
        logic        scl_drv;
        logic        sda_drv;
        t_result     expected_pins_q[$];
        int unsigned error_count;
        int unsigned beats_checked;

        function new();
            hold_ticks    = POST_WRITE_WAIT_RESET;
            seq           = SEQ_IDLE;
            sub           = 0;
            bit_cnt       = '0;
            bytes_left    = '0;
            shreg         = '0;
            hold_left     = '0;
            dev_addr      = '0;
            reg_addr      = '0;
            wr_byte       = '0;
            rd_xfer       = 1'b0;
            scl_drv       = 1'b1;
            sda_drv       = 1'b1;
            error_count   = 0;
            beats_checked = 0;
        endfunction

        function void set_hold_ticks(logic [15:0] value);
            hold_ticks = value;
        endfunction

        function int unsigned pending();
            return expected_pins_q.size();
        endfunction

        function bit is_idle();
            return seq == SEQ_IDLE;
        endfunction

        function void goto_seq(t_seq nxt);
            seq     = nxt;
            sub     = 0;
            bit_cnt = '0;
            case (nxt)
                SEQ_ADDR_W: shreg = {dev_addr, 1'b0};
                SEQ_ADDR_R: shreg = {dev_addr, 1'b1};
                SEQ_REG:    shreg = reg_addr;
                SEQ_DATA:   shreg = wr_byte;
                default:    ;
            endcase
        endfunction

        // advance one pin step for an accepted command beat and queue the pins after it
        function void note_command_beat(t_item it);
            t_result r;
            r = '0;
            if (seq == SEQ_IDLE) begin
                if (it.command == CMD_WRITE || it.command == CMD_READ) begin
                    dev_addr   = it.device_address;
                    reg_addr   = it.register_address;
                    wr_byte    = it.write_data;
                    bytes_left = (it.read_count == 8'd0) ? 8'd1 : it.read_count;
                    rd_xfer    = (it.command == CMD_READ);
                    goto_seq(SEQ_START);
                end
            end else if (it.command == CMD_TICK) begin
                case (seq)
                    SEQ_START, SEQ_RESTART: begin
                        case (sub)
                            0:       sda_drv = 1'b1;
                            1:       scl_drv = 1'b1;
                            2:       sda_drv = 1'b0;
                            default: scl_drv = 1'b0;
                        endcase
                        if (sub == 3) begin
                            goto_seq(seq == SEQ_START ? SEQ_ADDR_W : SEQ_ADDR_R);
                        end else begin
                            sub++;
                        end
                    end
                    SEQ_ADDR_W, SEQ_REG, SEQ_DATA, SEQ_ADDR_R: begin
                        if (sub == 0) begin
                            sda_drv = shreg[7];
                            sub     = 1;
                        end else if (sub == 1) begin
                            scl_drv = 1'b1;
                            sub     = 2;
                        end else begin
                            scl_drv = 1'b0;
                            shreg   = shreg << 1;
                            sub     = 0;
                            if (bit_cnt == 3'd7) begin
                                case (seq)
                                    SEQ_ADDR_W: goto_seq(SEQ_ACK_ADDR);
                                    SEQ_REG:    goto_seq(SEQ_ACK_REG);
                                    SEQ_DATA:   goto_seq(SEQ_ACK_DATA);
                                    default:    goto_seq(SEQ_ACK_ADDR_R);
                                endcase
                            end else begin
                                bit_cnt++;
                            end
                        end
                    end
                    SEQ_ACK_ADDR, SEQ_ACK_REG, SEQ_ACK_DATA, SEQ_ACK_ADDR_R: begin
                        case (sub)
                            0:       sda_drv = 1'b1;
                            1:       scl_drv = 1'b1;
                            2:       r.ack_missing = it.sda_in;
                            default: scl_drv = 1'b0;
                        endcase
                        if (sub == 3) begin
                            case (seq)
                                SEQ_ACK_ADDR: goto_seq(SEQ_REG);
                                SEQ_ACK_REG:  goto_seq(rd_xfer ? SEQ_RESTART : SEQ_DATA);
                                SEQ_ACK_DATA: goto_seq(SEQ_STOP);
                                default:      goto_seq(SEQ_RELEASE);
                            endcase
                        end else begin
                            sub++;
                        end
                    end
                    SEQ_RELEASE: begin
                        sda_drv = 1'b1;
                        goto_seq(SEQ_RD_BIT);
                        shreg = '0;
                    end
                    SEQ_RD_BIT: begin
                        if (sub == 0) begin
                            scl_drv = 1'b1;
                            sub     = 1;
                        end else if (sub == 1) begin
                            shreg = {shreg[6:0], it.sda_in};
                            sub   = 2;
                        end else begin
                            scl_drv = 1'b0;
                            sub     = 0;
                            if (bit_cnt == 3'd7) begin
                                seq     = SEQ_RD_ACK;
                                bit_cnt = '0;
                            end else begin
                                bit_cnt++;
                            end
                        end
                    end
                    SEQ_RD_ACK: begin
                        if (sub == 0) begin
                            sda_drv = (bytes_left > 8'd1) ? 1'b0 : 1'b1;
                            sub     = 1;
                        end else if (sub == 1) begin
                            scl_drv = 1'b1;
                            sub     = 2;
                        end else begin
                            scl_drv      = 1'b0;
                            r.read_data  = shreg;
                            r.read_valid = 1'b1;
                            if (bytes_left != 8'd0) bytes_left--;
                            goto_seq(bytes_left != 8'd0 ? SEQ_RELEASE : SEQ_STOP);
                        end
                    end
                    SEQ_STOP: begin
                        if (sub == 0) begin
                            sda_drv = 1'b0;
                            sub     = 1;
                        end else if (sub == 1) begin
                            scl_drv = 1'b1;
                            sub     = 2;
                        end else begin
                            sda_drv = 1'b1;
                            if (rd_xfer || hold_ticks == 16'd0) begin
                                r.done_res = 1'b1;
                                goto_seq(SEQ_IDLE);
                            end else begin
                                hold_left = hold_ticks;
                                goto_seq(SEQ_HOLD);
                            end
                        end
                    end
                    SEQ_HOLD: begin
                        if (hold_left != 16'd0) hold_left--;
                        if (hold_left == 16'd0) begin
                            r.done_res = 1'b1;
                            goto_seq(SEQ_IDLE);
                        end
                    end
                    default: goto_seq(SEQ_IDLE);
                endcase
            end
            r.scl      = scl_drv;
            r.sda_out  = sda_drv;
            r.busy_res = (seq != SEQ_IDLE);
            expected_pins_q.push_back(r);
        endfunction

        task report(string msg);
            error_count++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v) begin
                report($sformatf("result beat %0d %s: got %0h, expected %0h",
                                 beats_checked, name, got_v, want_v));
            end
        endtask

        task check_result_beat(t_result got);
            t_result want;
            if (expected_pins_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            want = expected_pins_q.pop_front();
            compare_field("scl", 8'(got.scl), 8'(want.scl));
            compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
            compare_field("ack_missing", 8'(got.ack_missing), 8'(want.ack_missing));
            compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
            beats_checked++;
        endtask
    endclass

endpackage

>>> tb/sv/i2c_register_master_core_tb.sv
// testbench of the i2c register master: directed and random command beats checked against a pin predictor
module i2c_register_master_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2crm_pkg::*;
    import i2crm_tb_pkg::*;

    // run limits, in ns and clock cycles
    localparam longint      WATCHDOG_NS   = 100_000_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_LIMIT     = 10_000;

    // byte address of the post-write wait register
    localparam logic [APB_ADDR_W-1:0] POST_WAIT_ADDR = APB_ADDR_W'(4 * REG_POST_WRITE_WAIT);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    i2crm_cmd_if cmd_bus ();
    i2crm_res_if res_bus ();

    pin_scoreboard sb;

    // random stalls on both sides are allowed while this is set
    bit          idling_on  = 1'b1;
    // once set, stalls stay off until the end of the run
    bit          tail_quiet = 1'b0;
    int unsigned stall_left = 0;

    i2c_register_master_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the master hangs
    initial begin
        #(WATCHDOG_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: take beats, with bursts of back-pressure while idling is on
    initial begin
        res_bus.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // every result beat taken is checked against the oldest predicted beat
    always @(posedge i_clk) begin : res_monitor
        t_result seen;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            seen.scl         = res_bus.scl;
            seen.sda_out     = res_bus.sda_out;
            seen.read_data   = res_bus.read_data;
            seen.read_valid  = res_bus.read_valid;
            seen.ack_missing = res_bus.ack_missing;
            seen.busy_res    = res_bus.busy_res;
            seen.done_res    = res_bus.done_res;
            sb.check_result_beat(seen);
        end
    end

    // a command beat with fixed operands, for the directed part
    function automatic t_item beat_of(logic [1:0] code, logic [6:0] dev, logic [7:0] ra,
                                      logic [7:0] wd, logic [7:0] cnt, logic sda);
        t_item it;
        it.command          = code;
        it.device_address   = dev;
        it.register_address = ra;
        it.write_data       = wd;
        it.read_count       = cnt;
        it.sda_in           = sda;
        return it;
    endfunction

    // a command beat with random operands; reads are kept short most of the time
    function automatic t_item random_beat(logic [1:0] code);
        t_item it;
        it.command          = code;
        it.device_address   = 7'($urandom_range(0, 127));
        it.register_address = 8'($urandom_range(0, 255));
        it.write_data       = 8'($urandom_range(0, 255));
        if (code == CMD_READ) begin
            it.read_count = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 9))
                                                         : 8'($urandom_range(1, 3));
        end else begin
            it.read_count = 8'($urandom_range(0, 255));
        end
        it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // present one beat, optionally after a gap, and note it once accepted
    task automatic send_beat(input t_item it);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        cmd_bus.valid            <= 1'b1;
        cmd_bus.command          <= it.command;
        cmd_bus.device_address   <= it.device_address;
        cmd_bus.register_address <= it.register_address;
        cmd_bus.write_data       <= it.write_data;
        cmd_bus.read_count       <= it.read_count;
        cmd_bus.sda_in           <= it.sda_in;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        sb.note_command_beat(it);
    endtask

    // tick the bus until the predicted sequence is back to idle
    task automatic run_to_idle();
        while (!sb.is_idle()) send_beat(random_beat(CMD_TICK));
    endtask

    // stop sending until every predicted result beat has come back
    task automatic hold_until_drained();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // bring the master to rest before touching its register
    task automatic settle();
        run_to_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup, then access until pready
    task automatic write_post_wait(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POST_WAIT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_hold_ticks(value);
    endtask

    // random traffic: mostly full transactions driven by ticks, some stray commands;
    // only beats that do something count toward n
    task automatic random_traffic(input int unsigned n);
        int unsigned counted;
        int unsigned since_toggle;
        t_item       it;
        counted      = 0;
        since_toggle = 0;
        while (counted < n) begin
            if (sb.is_idle()) begin
                case ($urandom_range(0, 9))
                    0:       it = random_beat(CMD_TICK);
                    1:       it = random_beat(CMD_UNUSED);
                    default: begin
                        it = random_beat($urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
                        counted++;
                    end
                endcase
            end else if ($urandom_range(0, 39) == 0) begin
                // command while busy, dropped by the master
                case ($urandom_range(0, 2))
                    0:       it = random_beat(CMD_WRITE);
                    1:       it = random_beat(CMD_READ);
                    default: it = random_beat(CMD_UNUSED);
                endcase
            end else begin
                it = random_beat(CMD_TICK);
                counted++;
            end
            send_beat(it);
            if (!tail_quiet && $urandom_range(0, 299) == 0) hold_until_drained();
            since_toggle++;
            // stretches with and without stalls
            if (since_toggle >= 120) begin
                since_toggle = 0;
                idling_on    = !tail_quiet && ($urandom_range(0, 3) != 0);
            end
        end
    endtask

    initial begin
        int unsigned waited;
        sb = new();
        i_rst_n                  <= 1'b0;
        cmd_bus.valid            <= 1'b0;
        cmd_bus.command          <= CMD_TICK;
        cmd_bus.device_address   <= '0;
        cmd_bus.register_address <= '0;
        cmd_bus.write_data       <= '0;
        cmd_bus.read_count       <= '0;
        cmd_bus.sda_in           <= 1'b1;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        paddr   <= POST_WAIT_ADDR;
        @(posedge i_clk);

        // post-write wait reads back its reset value
        if (prdata[15:0] !== POST_WRITE_WAIT_RESET) begin
            sb.report($sformatf("post-write wait after reset: got %0d, expected %0d",
                                prdata[15:0], POST_WRITE_WAIT_RESET));
        end

        // directed part, with a short post-write wait
        write_post_wait(16'd5);
        // tick and unused code while idle change nothing
        send_beat(beat_of(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        send_beat(beat_of(CMD_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        // write at the top of the address fields, then commands while busy
        send_beat(beat_of(CMD_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00, 1'b0));
        send_beat(beat_of(CMD_READ, 7'h12, 8'h34, 8'h56, 8'h05, 1'b0));
        send_beat(beat_of(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_beat(beat_of(CMD_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_beat(beat_of(CMD_WRITE, 7'h01, 8'h02, 8'h03, 8'h04, 1'b1));
        run_to_idle();
        // read with a zero count behaves as a one-byte read
        send_beat(beat_of(CMD_READ, 7'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
        run_to_idle();
        // two-byte read: ack on the first byte, nack on the last
        send_beat(beat_of(CMD_READ, 7'h55, 8'hAA, 8'h5A, 8'h02, 1'b0));
        run_to_idle();

        // zero wait: done comes on the last step of the stop
        settle();
        write_post_wait(16'd0);
        send_beat(beat_of(CMD_WRITE, 7'h2A, 8'h00, 8'hFF, 8'hFF, 1'b1));
        run_to_idle();
        random_traffic(200);

        settle();
        write_post_wait(16'd1);
        random_traffic(150);

        settle();
        write_post_wait(16'($urandom_range(2, 60)));
        random_traffic(200);

        // last part without stalls: a longer wait and a longer read
        tail_quiet = 1'b1;
        idling_on  = 1'b0;
        settle();
        write_post_wait(16'd30);
        send_beat(random_beat(CMD_WRITE));
        run_to_idle();
        send_beat(beat_of(CMD_READ, 7'h3C, 8'hC3, 8'h00, 8'h04, 1'b0));
        run_to_idle();
        settle();
        write_post_wait(16'($urandom_range(0, 20)));
        random_traffic(80);

        // wait for the tail of the results, then wait on for strays
        cmd_bus.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending() != 0 && waited < END_LIMIT);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d expected result beats never arrived", sb.pending()));
        end
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/i2crm_pkg.sv
rtl/i2crm_cmd_if.sv
rtl/i2crm_res_if.sv
rtl/i2crm_engine.sv
rtl/i2c_register_master_core.sv
rtl/i2crm_check.sv
tb/sv/i2crm_tb_pkg.sv
tb/sv/i2c_register_master_core_tb.sv
